// ===== src/aes128_block_cipher_macros.svh =====
// ----------------------------------------------------------------------------
// aes128 block cipher assertion macros
// shared property forms, clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef AES128_BLOCK_CIPHER_MACROS_SVH
`define AES128_BLOCK_CIPHER_MACROS_SVH

// same-cycle implication
`define AES_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("aes128 check failed");

// next-cycle implication
`define AES_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("aes128 check failed");

`endif

// ===== src/aes128_pkg.sv =====
// ----------------------------------------------------------------------------
// aes128_pkg
// shared types, tables and round functions of the aes-128 block cipher
// ----------------------------------------------------------------------------
`default_nettype none

package aes128_pkg;

  localparam int          RK_DEPTH   = 11;
  localparam int          RK_AW      = 4;
  localparam logic [3:0]  LAST_ROUND = 4'd10;

  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  localparam logic ACT_ENCRYPT = 1'b0;
  localparam logic ACT_DECRYPT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_FETCH,
    ST_ROUND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             load_in;
    logic             key_we;
    logic [RK_AW-1:0] key_addr;
    logic             keys_done;
    logic [RK_AW-1:0] rd_addr;
    logic             rnd_en;
    logic             rnd_first;
    logic             rnd_last;
    logic             out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic keys_ready;
    logic action;
  } dp_status_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] rcon(input logic [3:0] k);
    logic [7:0] r;
    case (k)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s);
    logic [127:0] r;
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = SBOX[s[127-8*i -: 8]];
    return r;
  endfunction

  function automatic logic [127:0] inv_sub_bytes(input logic [127:0] s);
    logic [127:0] r;
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = INV_SBOX[s[127-8*i -: 8]];
    return r;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s);
    logic [127:0] r;
    for (int c = 0; c < 4; c++)
      for (int w = 0; w < 4; w++)
        r[127-8*(c*4+w) -: 8] = s[127-8*(((c+w)%4)*4+w) -: 8];
    return r;
  endfunction

  function automatic logic [127:0] inv_shift_rows(input logic [127:0] s);
    logic [127:0] r;
    for (int c = 0; c < 4; c++)
      for (int w = 0; w < 4; w++)
        r[127-8*(c*4+w) -: 8] = s[127-8*(((c+4-w)%4)*4+w) -: 8];
    return r;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] r;
    logic [7:0]   a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      r[127-32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      r[119-32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      r[111-32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      r[103-32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return r;
  endfunction

  function automatic logic [7:0] gmul_inv(input logic [7:0] a, input logic [1:0] sel);
    logic [7:0] x2, x4, x8, r;
    x2 = xtime(a);
    x4 = xtime(x2);
    x8 = xtime(x4);
    case (sel)
      2'd0:    r = x8 ^ x4 ^ x2;
      2'd1:    r = x8 ^ x2 ^ a;
      2'd2:    r = x8 ^ x4 ^ a;
      default: r = x8 ^ a;
    endcase
    return r;
  endfunction

  // sel: 0 for 0e, 1 for 0b, 2 for 0d, 3 for 09
  function automatic logic [127:0] inv_mix_columns(input logic [127:0] s);
    logic [127:0] r;
    logic [7:0]   a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      r[127-32*c -: 8] = gmul_inv(a0, 2'd0) ^ gmul_inv(a1, 2'd1) ^
                         gmul_inv(a2, 2'd2) ^ gmul_inv(a3, 2'd3);
      r[119-32*c -: 8] = gmul_inv(a0, 2'd3) ^ gmul_inv(a1, 2'd0) ^
                         gmul_inv(a2, 2'd1) ^ gmul_inv(a3, 2'd2);
      r[111-32*c -: 8] = gmul_inv(a0, 2'd2) ^ gmul_inv(a1, 2'd3) ^
                         gmul_inv(a2, 2'd0) ^ gmul_inv(a3, 2'd1);
      r[103-32*c -: 8] = gmul_inv(a0, 2'd1) ^ gmul_inv(a1, 2'd2) ^
                         gmul_inv(a2, 2'd3) ^ gmul_inv(a3, 2'd0);
    end
    return r;
  endfunction

  function automatic logic [127:0] key_next(input logic [127:0] prev, input logic [3:0] k);
    logic [31:0] w3, t, n0, n1, n2, n3;
    w3 = prev[31:0];
    t  = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]} ^
         {rcon(k), 24'h000000};
    n0 = prev[127:96] ^ t;
    n1 = prev[95:64] ^ n0;
    n2 = prev[63:32] ^ n1;
    n3 = prev[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

endpackage

`default_nettype wire

// ===== src/aes128_channels.sv =====
// ----------------------------------------------------------------------------
// aes128 channels
// valid/ready interfaces for block input, result output and key writes
// ----------------------------------------------------------------------------
`default_nettype none

interface aes128_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [63:0] block_high;
  logic [63:0] block_low;
  modport source (output valid, action, block_high, block_low, input ready);
  modport sink (input valid, action, block_high, block_low, output ready);
endinterface

interface aes128_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  modport source (output valid, result_high, result_low, input ready);
  modport sink (input valid, result_high, result_low, output ready);
endinterface

interface aes128_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/aes128_block_cipher.sv =====
// ----------------------------------------------------------------------------
// aes128_block_cipher
// aes-128 encrypt/decrypt of one 128-bit block under a held key
// ----------------------------------------------------------------------------
// One block is processed at a time. With the round keys already expanded a
// block passes through acceptance, a fetch of the first round key from the
// round-key ram, the key add plus ten rounds on the single round unit, and
// a load of the result register. After a key write, the first block waits
// while the key schedule writes one round key per cycle into the ram. The
// result register lets a block be accepted while the previous result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_block_cipher (
  input  logic               clk,
  input  logic               rst,
  aes128_cfg_if.sink         cfg,
  aes128_in_if.sink          block,
  aes128_out_if.source       result
);
  import aes128_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg.ready = 1'b1;

  aes128_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (block.valid),
    .in_ready  (block.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  aes128_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .action      (block.action),
    .block_high  (block.block_high),
    .block_low   (block.block_low),
    .cmd         (cmd),
    .status      (status),
    .result_high (result.result_high),
    .result_low  (result.result_low)
  );

endmodule

`default_nettype wire

// ===== src/aes128_ram.sv =====
// ----------------------------------------------------------------------------
// aes128_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/aes128_dp.sv =====
// ----------------------------------------------------------------------------
// aes128_dp
// key registers, key schedule, round-key ram, round unit and result register
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [63:0]            cfg_data,
  input  logic                   action,
  input  logic [63:0]            block_high,
  input  logic [63:0]            block_low,
  input  aes128_pkg::ctrl_cmd_t  cmd,
  output aes128_pkg::dp_status_t status,
  output logic [63:0]            result_high,
  output logic [63:0]            result_low
);
  import aes128_pkg::*;

  logic [63:0]  key_high;
  logic [63:0]  key_low;
  logic         keys_ready;
  logic         act;
  logic [127:0] blk;
  logic [127:0] blk_next;
  logic [127:0] exp_prev;
  logic [127:0] rk_wdata;
  logic [127:0] rk;
  logic [127:0] enc_t;
  logic [127:0] dec_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high   <= '0;
      key_low    <= '0;
      keys_ready <= 1'b0;
    end else if (cfg_we) begin
      keys_ready <= 1'b0;
      case (cfg_index)
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_KEY_LOW:  key_low  <= cfg_data;
        default:      key_low  <= key_low;
      endcase
    end else if (cmd.keys_done) begin
      keys_ready <= 1'b1;
    end
  end

  // key schedule, one round key per cycle
  assign rk_wdata = (cmd.key_addr == '0) ? {key_high, key_low}
                                         : key_next(exp_prev, cmd.key_addr);

  always_ff @(posedge clk) begin
    if (cmd.key_we) begin
      exp_prev <= rk_wdata;
    end
  end

  aes128_ram #(
    .WIDTH (128),
    .DEPTH (RK_DEPTH)
  ) u_rk_ram (
    .clk   (clk),
    .we    (cmd.key_we),
    .waddr (cmd.key_addr),
    .wdata (rk_wdata),
    .raddr (cmd.rd_addr),
    .rdata (rk)
  );

  always_comb begin
    enc_t = shift_rows(sub_bytes(blk));
    if (!cmd.rnd_last) begin
      enc_t = mix_columns(enc_t);
    end
    dec_t = inv_sub_bytes(inv_shift_rows(blk)) ^ rk;
    if (!cmd.rnd_last) begin
      dec_t = inv_mix_columns(dec_t);
    end
    if (cmd.rnd_first) begin
      blk_next = blk ^ rk;
    end else if (act == ACT_DECRYPT) begin
      blk_next = dec_t;
    end else begin
      blk_next = enc_t ^ rk;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      blk <= {block_high, block_low};
      act <= action;
    end else if (cmd.rnd_en) begin
      blk <= blk_next;
    end
    if (cmd.out_load) begin
      result_high <= blk[127:64];
      result_low  <= blk[63:0];
    end
  end

  assign status.keys_ready = keys_ready;
  assign status.action     = act;

endmodule

`default_nettype wire

// ===== src/aes128_ctrl.sv =====
// ----------------------------------------------------------------------------
// aes128_ctrl
// sequencer for key expansion, round iteration and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

`include "aes128_block_cipher_macros.svh"

module aes128_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  aes128_pkg::dp_status_t status,
  output aes128_pkg::ctrl_cmd_t  cmd
);
  import aes128_pkg::*;

  state_t     state;
  state_t     state_next;
  logic [3:0] cnt;
  logic [3:0] cnt_next;
  logic [3:0] cnt_inc;

  assign cnt_inc = cnt + 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          cnt_next    = '0;
          state_next  = status.keys_ready ? ST_FETCH : ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        cmd.key_we   = 1'b1;
        cmd.key_addr = cnt;
        if (cnt == LAST_ROUND) begin
          cmd.keys_done = 1'b1;
          cnt_next      = '0;
          state_next    = ST_FETCH;
        end else begin
          cnt_next = cnt_inc;
        end
      end
      ST_FETCH: begin
        cmd.rd_addr = (status.action == ACT_DECRYPT) ? LAST_ROUND : '0;
        cnt_next    = '0;
        state_next  = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.rnd_en    = 1'b1;
        cmd.rnd_first = (cnt == '0);
        cmd.rnd_last  = (cnt == LAST_ROUND);
        if (cnt == LAST_ROUND) begin
          cmd.rd_addr = '0;
          state_next  = ST_DONE;
        end else begin
          cmd.rd_addr = (status.action == ACT_DECRYPT) ? LAST_ROUND - cnt_inc : cnt_inc;
          cnt_next    = cnt_inc;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `AES_ASSERT_IMPL(a_round_cnt, state == ST_ROUND, cnt <= LAST_ROUND)
  `AES_ASSERT_IMPL(a_no_overwrite, cmd.out_load, !out_valid || out_ready)
  `AES_ASSERT_NEXT(a_accept_start, in_valid && in_ready,
                   state == ST_EXPAND || state == ST_FETCH)
  `AES_ASSERT_NEXT(a_expand_end, state == ST_EXPAND && cnt == LAST_ROUND,
                   state == ST_FETCH)

endmodule

`default_nettype wire
